/* hdl/swbr_pkg.sv */
package swbr_pkg;

   localparam int HISTORY_DEPTH_DEF = 16;

   localparam int DATA_W    = 32;
   localparam int CNT_W     = 31;
   localparam int WIN_W     = 5;
   localparam int STEP_W    = 5;
   localparam int NUM_LANES = 4;
   localparam int CSR_AW    = 5;

   localparam logic [WIN_W-1:0]  WINDOW_RST = 5'd10;
   localparam logic [STEP_W-1:0] STEP_RST   = 5'd11;
   localparam logic [DATA_W-1:0] WEIGHT_RST = 32'd1;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_HALT   = 2'd1,
      ACT_RESUME = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      REG_BUDGET   = 3'd0,
      REG_WINDOW   = 3'd1,
      REG_W_LLC_RD = 3'd2,
      REG_W_LLC_WR = 3'd3,
      REG_W_MEM_RD = 3'd4,
      REG_W_MEM_WR = 3'd5
   } reg_index_type;

   // effective window is already clamped to 1..depth, at most 31
   typedef struct packed {
      logic [DATA_W-1:0] budget;
      logic [WIN_W-1:0]  window;
   } cfg_type;

   typedef struct packed {
      action_type        action;
      logic              halted;
      logic [DATA_W-1:0] set_point;
      logic [DATA_W-1:0] usage;
      logic [DATA_W-1:0] halt_count;
   } rsp_type;

endpackage

/* hdl/swbr_lane.sv */
module swbr_lane import swbr_pkg::*; (
   input  logic              clock,
   input  logic              load,
   input  logic [DATA_W-1:0] weight,
   input  logic [CNT_W-1:0]  count,
   output logic [DATA_W-1:0] product
);

   logic [DATA_W-1:0] product_ff;
   logic [DATA_W-1:0] product_in;

   // low 32 bits of the product only
   assign product_in = weight * DATA_W'(count);

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

/* hdl/swbr_merge.sv */
module swbr_merge import swbr_pkg::*; (
   input  logic                             clock,
   input  logic                             load,
   input  logic [NUM_LANES-1:0][DATA_W-1:0] products,
   output logic [DATA_W-1:0]                usage
);

   logic [DATA_W-1:0] usage_ff;
   logic [DATA_W-1:0] usage_in;

   always_comb begin
      usage_in = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         usage_in = usage_in + products[i];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         usage_ff <= usage_in;
      end
   end

   assign usage = usage_ff;

endmodule

/* hdl/swbr_ctrl.sv */
module swbr_ctrl import swbr_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              dec_fire,
   input  logic [DATA_W-1:0] usage,
   input  cfg_type           cfg,
   output rsp_type           rsp
);

   localparam int SLOT_W = $clog2(HISTORY_DEPTH);
   localparam int CMP_W  = (SLOT_W + 1 > WIN_W) ? SLOT_W + 1 : WIN_W;

   logic [DATA_W-1:0]        hist_mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] hist_vld_ff;
   logic [DATA_W-1:0]        rd_data_ff;
   logic                     rd_vld_ff;
   logic [SLOT_W-1:0]        rd_addr;

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] last_ff, last_in;
   logic [DATA_W-1:0] rec_sp_ff, rec_sp_in;
   logic              halted_ff, halted_in;
   logic [DATA_W-1:0] halt_cnt_ff, halt_cnt_in;
   logic              dec_d1_ff;
   logic [DATA_W-1:0] mul_ff, mul_in;
   logic [DATA_W-1:0] wb_ff, wb_in;
   rsp_type           rsp_ff, rsp_in;

   logic              in_rec;
   logic [DATA_W-1:0] hist_val;
   logic [DATA_W-1:0] sp;
   logic [DATA_W-1:0] diff;
   logic              cap;
   logic [DATA_W-1:0] wr_data;
   action_type        action;

   function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] slot,
                                                   input logic [WIN_W-1:0]  win);
      logic [CMP_W-1:0] nxt;
      nxt = CMP_W'(slot) + CMP_W'(1);
      if (nxt >= CMP_W'(win)) begin
         return '0;
      end
      return nxt[SLOT_W-1:0];
   endfunction

   assign mul_in = DATA_W'(step_ff) * cfg.budget;
   assign wb_in  = DATA_W'(cfg.window) * cfg.budget;

   assign in_rec   = (step_ff <= cfg.window);
   assign hist_val = rd_vld_ff ? rd_data_ff : '0;
   assign sp       = in_rec ? rec_sp_ff : hist_val + wb_ff;
   assign diff     = sp - usage;
   assign cap      = diff[DATA_W-1];
   assign wr_data  = cap ? sp : usage;

   assign slot_in = dec_fire ? slot_after(slot_ff, cfg.window) : slot_ff;
   assign rd_addr = slot_in;

   // rec_sp_ff tracks last capped point + step * budget by adds; when quiet it is
   // rebuilt from the registered product so a new budget takes effect
   always_comb begin
      step_in     = step_ff;
      last_in     = last_ff;
      halted_in   = halted_ff;
      halt_cnt_in = halt_cnt_ff;
      action      = ACT_NONE;
      rec_sp_in   = (!dec_fire && !dec_d1_ff) ? last_ff + mul_ff : rec_sp_ff;
      if (dec_fire) begin
         if (cap) begin
            step_in   = STEP_W'(1);
            last_in   = sp;
            rec_sp_in = sp + cfg.budget;
            if (!halted_ff) begin
               halted_in   = 1'b1;
               halt_cnt_in = halt_cnt_ff + DATA_W'(1);
               action      = ACT_HALT;
            end
         end else begin
            if (in_rec) begin
               step_in   = step_ff + STEP_W'(1);
               rec_sp_in = rec_sp_ff + cfg.budget;
            end
            if (halted_ff) begin
               halted_in = 1'b0;
               action    = ACT_RESUME;
            end
         end
      end
   end

   always_comb begin
      rsp_in.action     = action;
      rsp_in.halted     = halted_in;
      rsp_in.set_point  = sp;
      rsp_in.usage      = usage;
      rsp_in.halt_count = halt_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (dec_fire) begin
         hist_mem[slot_ff] <= wr_data;
      end
      if (dec_fire && slot_ff == rd_addr) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= hist_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
      wb_ff  <= wb_in;
      if (dec_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
         slot_ff     <= '0;
         step_ff     <= STEP_RST;
         last_ff     <= '0;
         rec_sp_ff   <= '0;
         halted_ff   <= 1'b0;
         halt_cnt_ff <= '0;
         dec_d1_ff   <= 1'b0;
      end else begin
         if (dec_fire) begin
            hist_vld_ff[slot_ff] <= 1'b1;
         end
         rd_vld_ff   <= (dec_fire && slot_ff == rd_addr) ? 1'b1 : hist_vld_ff[rd_addr];
         slot_ff     <= slot_in;
         step_ff     <= step_in;
         last_ff     <= last_in;
         rec_sp_ff   <= rec_sp_in;
         halted_ff   <= halted_in;
         halt_cnt_ff <= halt_cnt_in;
         dec_d1_ff   <= dec_fire;
      end
   end

   assign rsp = rsp_ff;

`ifndef ASSERT_OFF
   a_halt_counts: assert property (@(posedge clock) disable iff (reset)
      (dec_fire && rsp_in.action == ACT_HALT) |=> (halt_cnt_ff == $past(halt_cnt_ff) + 32'd1))
      else $error("halt issued without count increment");

   a_halt_running: assert property (@(posedge clock) disable iff (reset)
      (dec_fire && rsp_in.action == ACT_HALT) |-> !halted_ff)
      else $error("halt issued while core already halted");

   a_resume_halted: assert property (@(posedge clock) disable iff (reset)
      (dec_fire && rsp_in.action == ACT_RESUME) |-> (halted_ff && !rsp_in.halted))
      else $error("resume issued while core running");

   a_cap_restarts: assert property (@(posedge clock) disable iff (reset)
      (dec_fire && cap) |=> (step_ff == 5'd1 && last_ff == $past(sp)))
      else $error("cap did not restart recovery");
`endif

endmodule

/* hdl/sliding_window_bandwidth_regulator.sv */
// Pipeline: an accepted request beat is registered in the lane product registers, then
// in the weighted-sum register, then the set-point decision goes into the output register.
// Throughput: one beat per cycle while rsp_ready does not hold back the output.
// Reset: synchronous, active high; config registers return to defaults, history reads
// as zero through per-entry valid flags, so no clearing pass is needed.
module sliding_window_bandwidth_regulator import swbr_pkg::*; #(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CNT_W-1:0]  req_llc_reads,
   input  logic [CNT_W-1:0]  req_llc_writes,
   input  logic [CNT_W-1:0]  req_mem_reads,
   input  logic [CNT_W-1:0]  req_mem_writes,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_core_action,
   output logic              rsp_core_halted,
   output logic [DATA_W-1:0] rsp_set_point,
   output logic [DATA_W-1:0] rsp_usage,
   output logic [DATA_W-1:0] rsp_halt_count,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int WIN_CAP = (HISTORY_DEPTH < 31) ? HISTORY_DEPTH : 31;

   logic [DATA_W-1:0]                budget_ff, budget_in;
   logic [WIN_W-1:0]                 window_ff, window_in;
   logic [NUM_LANES-1:0][DATA_W-1:0] weight_ff, weight_in;
   reg_index_type                    reg_idx;
   logic                             csr_wr;

   logic [NUM_LANES-1:0][CNT_W-1:0]  counts;
   logic [NUM_LANES-1:0][DATA_W-1:0] products;
   logic [DATA_W-1:0]                usage;
   logic [WIN_W-1:0]                 win_eff;
   cfg_type                          cfg;
   rsp_type                          rsp;

   logic prod_v_ff, prod_v_in;
   logic sum_v_ff, sum_v_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, dec_fire, sum_load, accept;

   // ---- config registers ----
   assign reg_idx = reg_index_type'(paddr[CSR_AW-1:2]);
   assign csr_wr  = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      budget_in = budget_ff;
      window_in = window_ff;
      weight_in = weight_ff;
      if (csr_wr) begin
         case (reg_idx)
            REG_BUDGET:   budget_in    = pwdata;
            REG_WINDOW:   window_in    = pwdata[WIN_W-1:0];
            REG_W_LLC_RD: weight_in[0] = pwdata;
            REG_W_LLC_WR: weight_in[1] = pwdata;
            REG_W_MEM_RD: weight_in[2] = pwdata;
            REG_W_MEM_WR: weight_in[3] = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_BUDGET:   prdata = budget_ff;
         REG_WINDOW:   prdata = DATA_W'(window_ff);
         REG_W_LLC_RD: prdata = weight_ff[0];
         REG_W_LLC_WR: prdata = weight_ff[1];
         REG_W_MEM_RD: prdata = weight_ff[2];
         REG_W_MEM_WR: prdata = weight_ff[3];
         default:      prdata = '0;
      endcase
   end

   // zero acts as one, oversize clamps to history depth (at most 31)
   always_comb begin
      if (window_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (window_ff > WIN_W'(WIN_CAP)) begin
         win_eff = WIN_W'(WIN_CAP);
      end else begin
         win_eff = window_ff;
      end
   end

   assign cfg.budget = budget_ff;
   assign cfg.window = win_eff;

   // ---- pipeline flow ----
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign dec_fire  = sum_v_ff && out_free;
   assign sum_load  = prod_v_ff && (!sum_v_ff || dec_fire);
   assign req_ready = !prod_v_ff || sum_load;
   assign accept    = req_valid && req_ready;

   assign prod_v_in    = accept || (prod_v_ff && !sum_load);
   assign sum_v_in     = sum_load || (sum_v_ff && !dec_fire);
   assign rsp_valid_in = dec_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff    <= '0;
         window_ff    <= WINDOW_RST;
         weight_ff    <= {NUM_LANES{WEIGHT_RST}};
         prod_v_ff    <= 1'b0;
         sum_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         budget_ff    <= budget_in;
         window_ff    <= window_in;
         weight_ff    <= weight_in;
         prod_v_ff    <= prod_v_in;
         sum_v_ff     <= sum_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---- lanes ----
   assign counts[0] = req_llc_reads;
   assign counts[1] = req_llc_writes;
   assign counts[2] = req_mem_reads;
   assign counts[3] = req_mem_writes;

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      swbr_lane u_lane (
         .clock   (clock),
         .load    (accept),
         .weight  (weight_ff[i]),
         .count   (counts[i]),
         .product (products[i])
      );
   end

   swbr_merge u_merge (
      .clock    (clock),
      .load     (sum_load),
      .products (products),
      .usage    (usage)
   );

   swbr_ctrl #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .dec_fire (dec_fire),
      .usage    (usage),
      .cfg      (cfg),
      .rsp      (rsp)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_core_action = rsp.action;
   assign rsp_core_halted = rsp.halted;
   assign rsp_set_point   = rsp.set_point;
   assign rsp_usage       = rsp.usage;
   assign rsp_halt_count  = rsp.halt_count;

endmodule

/* sim/sliding_window_bandwidth_regulator_tb.sv */
module sliding_window_bandwidth_regulator_tb import swbr_pkg::*;;

   localparam int HIST_DEPTH      = HISTORY_DEPTH_DEF;
   localparam int LIMIT_CYCLES    = 300000;
   localparam int PHASES          = 8;
   localparam int PERIODS_A_PHASE = 181;
   localparam int LONG_HOLD       = 400;
   localparam logic [CNT_W-1:0] CNT_MAX = 31'h7FFFFFFF;

   typedef struct packed {
      logic [CNT_W-1:0] llc_rd;
      logic [CNT_W-1:0] llc_wr;
      logic [CNT_W-1:0] mem_rd;
      logic [CNT_W-1:0] mem_wr;
   } counter_sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [CNT_W-1:0]  req_llc_reads = '0;
   logic [CNT_W-1:0]  req_llc_writes = '0;
   logic [CNT_W-1:0]  req_mem_reads = '0;
   logic [CNT_W-1:0]  req_mem_writes = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [1:0]        rsp_core_action;
   logic              rsp_core_halted;
   logic [DATA_W-1:0] rsp_set_point;
   logic [DATA_W-1:0] rsp_usage;
   logic [DATA_W-1:0] rsp_halt_count;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   sliding_window_bandwidth_regulator #(.HISTORY_DEPTH(HIST_DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_llc_reads(req_llc_reads), .req_llc_writes(req_llc_writes),
      .req_mem_reads(req_mem_reads), .req_mem_writes(req_mem_writes),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_core_action(rsp_core_action), .rsp_core_halted(rsp_core_halted),
      .rsp_set_point(rsp_set_point), .rsp_usage(rsp_usage),
      .rsp_halt_count(rsp_halt_count),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #2 clock = ~clock;

   // ---------------- regulator copy: config and state ----------------
   logic [DATA_W-1:0] budget_cfg;
   logic [WIN_W-1:0]  window_cfg;
   logic [DATA_W-1:0] weight_cfg [4];
   logic [DATA_W-1:0] hist_mem [HIST_DEPTH];
   int unsigned       next_slot;
   int unsigned       recov_step;
   logic [DATA_W-1:0] capped_point;
   logic              core_held;
   logic [DATA_W-1:0] halts_total;

   counter_sample_type pending_periods [$];
   rsp_type            expected_decisions [$];

   int  err_count = 0;
   int  cycle_count = 0;
   bit  idling_on = 1'b0;
   int  long_hold_asks = 0;
   int  long_hold_done = 0;
   int  long_hold_left = 0;
   int  send_gap = 0;
   int  stall_gap = 0;
   logic req_took = 1'b0;
   counter_sample_type next_period;
   counter_sample_type got_period;
   rsp_type            want;

   function automatic void model_reset();
      budget_cfg = '0;
      window_cfg = WINDOW_RST;
      for (int k = 0; k < 4; k++) weight_cfg[k] = WEIGHT_RST;
      for (int k = 0; k < HIST_DEPTH; k++) hist_mem[k] = '0;
      next_slot    = 0;
      recov_step   = STEP_RST;
      capped_point = '0;
      core_held    = 1'b0;
      halts_total  = '0;
   endfunction

   function automatic rsp_type regulate_period(input counter_sample_type s);
      rsp_type           r;
      int unsigned       w;
      int unsigned       idx;
      logic [DATA_W-1:0] sp;
      logic [DATA_W-1:0] use_sum;
      logic [DATA_W-1:0] diff;
      w = (window_cfg == 0) ? 1 : ((window_cfg > HIST_DEPTH) ? HIST_DEPTH : window_cfg);
      idx = (next_slot >= HIST_DEPTH) ? 0 : next_slot;
      if (recov_step < w + 1) begin
         sp = capped_point + recov_step * budget_cfg;
         recov_step++;
      end else begin
         sp = hist_mem[idx] + w * budget_cfg;
      end
      use_sum = weight_cfg[0] * s.llc_rd + weight_cfg[1] * s.llc_wr
              + weight_cfg[2] * s.mem_rd + weight_cfg[3] * s.mem_wr;
      diff = sp - use_sum;
      r.action = ACT_NONE;
      if (diff[DATA_W-1]) begin
         hist_mem[idx] = sp;
         recov_step    = 1;
         capped_point  = sp;
         if (!core_held) begin
            core_held = 1'b1;
            halts_total++;
            r.action = ACT_HALT;
         end
      end else begin
         hist_mem[idx] = use_sum;
         if (core_held) begin
            core_held = 1'b0;
            r.action = ACT_RESUME;
         end
      end
      next_slot    = (idx + 1 >= w) ? 0 : idx + 1;
      r.halted     = core_held;
      r.set_point  = sp;
      r.usage      = use_sum;
      r.halt_count = halts_total;
      return r;
   endfunction

   // ---------------- request driver ----------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (send_gap != 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            send_gap  <= $urandom_range(0, 8);
            req_valid <= 1'b0;
         end else if (pending_periods.size() != 0) begin
            next_period = pending_periods.pop_front();
            req_valid      <= 1'b1;
            req_llc_reads  <= next_period.llc_rd;
            req_llc_writes <= next_period.llc_wr;
            req_mem_reads  <= next_period.mem_rd;
            req_mem_writes <= next_period.mem_wr;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------- result receiver ----------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_hold_left != 0) begin
         rsp_ready      <= 1'b0;
         long_hold_left <= long_hold_left - 1;
      end else if (long_hold_asks > long_hold_done) begin
         rsp_ready      <= 1'b0;
         long_hold_done <= long_hold_done + 1;
         long_hold_left <= LONG_HOLD;
      end else if (stall_gap != 0) begin
         rsp_ready <= 1'b0;
         stall_gap <= stall_gap - 1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         stall_gap <= $urandom_range(0, 8);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------- prediction and checking ----------------
   always @(posedge clock) begin
      req_took <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            got_period = '{req_llc_reads, req_llc_writes, req_mem_reads, req_mem_writes};
            expected_decisions.push_back(regulate_period(got_period));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_decisions.size() == 0) begin
               $error("result beat with nothing expected");
               err_count++;
            end else begin
               want = expected_decisions.pop_front();
               if (rsp_core_action !== want.action) begin
                  $error("core_action: expected %0d, got %0d", want.action, rsp_core_action);
                  err_count++;
               end
               if (rsp_core_halted !== want.halted) begin
                  $error("core_halted: expected %0d, got %0d", want.halted, rsp_core_halted);
                  err_count++;
               end
               if (rsp_set_point !== want.set_point) begin
                  $error("set_point: expected %h, got %h", want.set_point, rsp_set_point);
                  err_count++;
               end
               if (rsp_usage !== want.usage) begin
                  $error("usage: expected %h, got %h", want.usage, rsp_usage);
                  err_count++;
               end
               if (rsp_halt_count !== want.halt_count) begin
                  $error("halt_count: expected %h, got %h", want.halt_count, rsp_halt_count);
                  err_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("sliding_window_bandwidth_regulator_tb: done, errors");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [DATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_reg(input reg_index_type idx, input logic [DATA_W-1:0] val);
      csr_write(CSR_AW'(4 * int'(idx)), val);
      case (idx)
         REG_BUDGET:   budget_cfg = val;
         REG_WINDOW:   window_cfg = val[WIN_W-1:0];
         REG_W_LLC_RD: weight_cfg[0] = val;
         REG_W_LLC_WR: weight_cfg[1] = val;
         REG_W_MEM_RD: weight_cfg[2] = val;
         REG_W_MEM_WR: weight_cfg[3] = val;
         default: ;
      endcase
   endtask

   task automatic set_weights(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                              input logic [DATA_W-1:0] c, input logic [DATA_W-1:0] d);
      set_reg(REG_W_LLC_RD, a);
      set_reg(REG_W_LLC_WR, b);
      set_reg(REG_W_MEM_RD, c);
      set_reg(REG_W_MEM_WR, d);
   endtask

   task automatic push_period(input logic [CNT_W-1:0] a, input logic [CNT_W-1:0] b,
                              input logic [CNT_W-1:0] c, input logic [CNT_W-1:0] d);
      pending_periods.push_back('{a, b, c, d});
   endtask

   task automatic wait_drained();
      while (pending_periods.size() != 0 || expected_decisions.size() != 0 || req_valid)
         @(negedge clock);
   endtask

   initial begin
      logic [CNT_W-1:0]  run_cnt [4];
      logic [WIN_W-1:0]  win;
      logic [DATA_W-1:0] bud;
      longint unsigned   wsum;
      int                inc_top;
      int                roll;

      model_reset();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      idling_on = 1'b1;

      // defaults: zero budget, window ten, unit weights
      push_period('0, '0, '0, '0);
      push_period(CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX);   // wraps, difference stays positive
      push_period(31'd1, '0, '0, '0);                    // over budget: halt
      push_period('0, '0, '0, 31'd5);                    // over again while halted
      push_period('0, '0, '0, '0);                       // back under: resume
      push_period(31'h55555555, 31'h2AAAAAAA, 31'h55555555, 31'h2AAAAAAA);
      wait_drained();

      set_reg(REG_BUDGET, 32'hFFFFFFFF);
      set_reg(REG_WINDOW, 32'd1);
      set_weights(32'hFFFFFFFF, 32'd0, 32'h80000000, 32'd1);
      push_period(CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX);
      push_period('0, '0, '0, '0);
      push_period(31'd1, 31'd1, 31'd1, 31'd1);
      push_period(31'h2AAAAAAA, 31'h55555555, 31'h2AAAAAAA, 31'h55555555);
      wait_drained();

      // zero window acts as one
      set_reg(REG_WINDOW, 32'd0);
      set_reg(REG_BUDGET, 32'd1);
      set_weights(32'd1, 32'd1, 32'd1, 32'd1);
      push_period(31'd3, '0, '0, '0);
      push_period(31'd3, '0, '0, '0);
      push_period(31'd4, '0, '0, 31'd1);
      wait_drained();

      // window above depth is clamped; unmapped addresses must not disturb anything
      set_reg(REG_WINDOW, 32'd31);
      set_reg(REG_BUDGET, 32'h7FFFFFFF);
      for (int k = int'(REG_W_MEM_WR) + 1; k < (1 << (CSR_AW - 2)); k++)
         csr_write(CSR_AW'(4 * k), $urandom);
      push_period(CNT_MAX, '0, '0, '0);
      push_period('0, CNT_MAX, '0, '0);
      push_period('0, '0, CNT_MAX, CNT_MAX);
      push_period(31'd100, 31'd200, 31'd300, 31'd400);

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         case (p)
            0: win = 5'd1;
            1: win = 5'd16;
            2: win = 5'd0;
            3: win = 5'd31;
            4: win = 5'd5;
            5: win = 5'($urandom);
            6: win = 5'd17;
            default: win = 5'($urandom_range(2, 16));
         endcase
         if (p == 5) begin
            bud = $urandom;
            set_weights($urandom, $urandom, $urandom, $urandom);
            set_reg(REG_WINDOW, {27'($urandom), win});
         end else if (p == 6) begin
            bud = 32'hFFFFFFFF;
            set_weights(32'd0, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF);
            set_reg(REG_WINDOW, {27'd0, win});
         end else begin
            bud = $urandom_range(50, 5000);
            set_weights($urandom_range(1, 8), $urandom_range(1, 8),
                        $urandom_range(1, 8), $urandom_range(1, 8));
            set_reg(REG_WINDOW, {27'd0, win});
         end
         set_reg(REG_BUDGET, bud);

         wsum = 64'(weight_cfg[0]) + weight_cfg[1] + weight_cfg[2] + weight_cfg[3];
         if (wsum == 0 || wsum > 64) inc_top = 1000;
         else inc_top = int'((2 * longint'(bud)) / wsum) + 1;
         for (int k = 0; k < 4; k++)
            run_cnt[k] = (p % 3 == 2) ? CNT_MAX - CNT_W'($urandom_range(0, 20000))
                                      : CNT_W'($urandom);
         if (p == PHASES - 1) idling_on = 1'b0;

         for (int i = 0; i < PERIODS_A_PHASE; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
               push_period(CNT_W'($urandom), CNT_W'($urandom), CNT_W'($urandom),
                           CNT_W'($urandom));
            end else begin
               for (int k = 0; k < 4; k++) begin
                  if (roll < 13) run_cnt[k] = '0;   // counters restarted
                  else if (roll < 16) run_cnt[k] += CNT_W'(50 * $urandom_range(0, inc_top));
                  else run_cnt[k] += CNT_W'($urandom_range(0, inc_top));
               end
               push_period(run_cnt[0], run_cnt[1], run_cnt[2], run_cnt[3]);
            end
         end
         // receiver holds off while the sender keeps offering beats
         if (p == 1) long_hold_asks++;
      end

      wait_drained();
      repeat (10) @(negedge clock);
      if (expected_decisions.size() != 0) begin
         $error("%0d results never arrived", expected_decisions.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("sliding_window_bandwidth_regulator_tb: done, clean");
      end else begin
         $display("sliding_window_bandwidth_regulator_tb: done, errors");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/swbr_pkg.sv
hdl/swbr_lane.sv
hdl/swbr_merge.sv
hdl/swbr_ctrl.sv
hdl/sliding_window_bandwidth_regulator.sv
sim/sliding_window_bandwidth_regulator_tb.sv
